// ===== sv/dcl_pkg.sv =====
// shared types and constants of the density cluster labeler
// no dependencies
package dcl_pkg;

  localparam int DIMS       = 4;
  localparam int COORD_BITS = 16;
  localparam int PT_BITS    = DIMS * COORD_BITS;
  localparam int DIFF_BITS  = COORD_BITS;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;
  localparam int EPS_BITS   = 34;
  localparam int MINP_BITS  = 7;
  localparam int DIMSEL_BITS = 3;
  localparam int CFG_IDX_BITS = 2;
  localparam int IDX_OUT_BITS = 6;
  localparam int LBL_OUT_BITS = 7;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_POINTS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EPS_SQUARED = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIMS_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    SCAN_COUNT,
    SCAN_SEED,
    SCAN_EXP
  } scan_mode_e;

  typedef struct packed {
    logic       ld;
    logic       lbl_rd_i;
    logic       p_from_i;
    logic       p_from_q;
    logic       cen_rd;
    logic       cen_ld;
    logic       scan_go;
    scan_mode_e scan_mode;
    logic       noise_wr;
    logic       i_inc;
    logic       i_clr;
    logic       c_inc;
    logic       q_clr;
    logic       q_pop;
    logic       out_ld;
    logic       set_clr;
  } cmd_t;

  typedef struct packed {
    logic i_at_end;
    logic lbl_unclass;
    logic core;
    logic scan_done;
    logic q_empty;
    logic out_free;
  } status_t;

endpackage

// ===== sv/dcl_if.sv =====
// point and label channels with valid/ready handshake
// depends on dcl_pkg
interface dcl_pt_if;
  logic                            valid;
  logic                            ready;
  logic signed [dcl_pkg::COORD_BITS-1:0] coord_a;
  logic signed [dcl_pkg::COORD_BITS-1:0] coord_b;
  logic signed [dcl_pkg::COORD_BITS-1:0] coord_c;
  logic signed [dcl_pkg::COORD_BITS-1:0] coord_d;
  logic                            final_point;
  modport source (output valid, coord_a, coord_b, coord_c, coord_d, final_point, input ready);
  modport sink (input valid, coord_a, coord_b, coord_c, coord_d, final_point, output ready);
endinterface

interface dcl_lbl_if;
  logic                                valid;
  logic                                ready;
  logic [dcl_pkg::IDX_OUT_BITS-1:0]    point_index;
  logic [dcl_pkg::LBL_OUT_BITS-1:0]    cluster_label;
  logic                                last_label;
  modport source (output valid, point_index, cluster_label, last_label, input ready);
  modport sink (input valid, point_index, cluster_label, last_label, output ready);
endinterface

// ===== sv/density_cluster_labeler_core.sv =====
// density clustering of a loaded point set, one label per point in index order
// points load at one per cycle while in the load state; after the final point each
// neighbour scan reads the coordinate store once per cycle, one read per stored point;
// labels then leave one by one as the output register frees; asynchronous active-low reset
// clears the set and sets min_points 4, eps_squared 1, dims_in_use 4
module density_cluster_labeler_core #(
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  dcl_pt_if.sink                           pt_i,
  dcl_lbl_if.source                        lbl_o,
  input  logic                             cfg_we_i,
  input  logic [dcl_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [dcl_pkg::EPS_BITS-1:0]     cfg_wdata_i
);

  dcl_pkg::cmd_t    cmd;
  dcl_pkg::status_t sts;
  logic             in_ready;

  assign pt_i.ready = in_ready;

  dcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pt_i.valid),
    .in_final_i (pt_i.final_point),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dcl_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pt_data_i       ({pt_i.coord_d, pt_i.coord_c, pt_i.coord_b, pt_i.coord_a}),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (lbl_o.valid),
    .out_ready_i     (lbl_o.ready),
    .point_index_o   (lbl_o.point_index),
    .cluster_label_o (lbl_o.cluster_label),
    .last_label_o    (lbl_o.last_label)
  );

endmodule

// ===== sv/dcl_datapath.sv =====
// point, label and seed memories, distance pipeline, counters and output register
// depends on dcl_pkg
module dcl_datapath #(
  parameter int MAX_POINTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dcl_pkg::cmd_t                       cmd_i,
  output dcl_pkg::status_t                    sts_o,
  input  logic [dcl_pkg::PT_BITS-1:0]         pt_data_i,
  input  logic                                cfg_we_i,
  input  logic [dcl_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [dcl_pkg::EPS_BITS-1:0]        cfg_wdata_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dcl_pkg::IDX_OUT_BITS-1:0]    point_index_o,
  output logic [dcl_pkg::LBL_OUT_BITS-1:0]    cluster_label_o,
  output logic                                last_label_o
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int LW = NW;
  localparam int CW = $clog2(MAX_POINTS + 2);
  localparam int KW = NW + dcl_pkg::MINP_BITS;
  localparam logic [NW-1:0] N_MAX = NW'(MAX_POINTS);

  // config registers
  logic [dcl_pkg::MINP_BITS-1:0]   minp_q;
  logic [dcl_pkg::EPS_BITS-1:0]    eps_q;
  logic [dcl_pkg::DIMSEL_BITS-1:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minp_q <= dcl_pkg::MINP_BITS'(4);
      eps_q  <= dcl_pkg::EPS_BITS'(1);
      dims_q <= dcl_pkg::DIMSEL_BITS'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dcl_pkg::CFG_MIN_POINTS:  minp_q <= cfg_wdata_i[dcl_pkg::MINP_BITS-1:0];
        dcl_pkg::CFG_EPS_SQUARED: eps_q  <= cfg_wdata_i;
        dcl_pkg::CFG_DIMS_IN_USE: dims_q <= cfg_wdata_i[dcl_pkg::DIMSEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [dcl_pkg::DIMSEL_BITS-1:0] dims_act;
  always_comb begin
    dims_act = dims_q;
    if (dims_q == '0) dims_act = dcl_pkg::DIMSEL_BITS'(1);
    if (dims_q > dcl_pkg::DIMSEL_BITS'(dcl_pkg::DIMS)) dims_act = dcl_pkg::DIMSEL_BITS'(dcl_pkg::DIMS);
  end

  // counters
  logic [NW-1:0] n_q, i_q, head_q, tail_q, q_iss_q, cnt_q;
  logic [CW-1:0] c_q;
  logic [IW-1:0] p_q;
  logic          issuing_q;
  dcl_pkg::scan_mode_e mode_q;

  // pipeline
  logic          va_q, vb_q, vc_q;
  logic [IW-1:0] qa_q, qb_q, qc_q;
  logic [dcl_pkg::SQ_BITS-1:0]  sq_q [dcl_pkg::DIMS];
  logic [dcl_pkg::SQ_BITS-1:0]  sq_d [dcl_pkg::DIMS];
  logic [dcl_pkg::SUM_BITS-1:0] sum_q, sum_d;
  logic [dcl_pkg::PT_BITS-1:0]  center_q;

  // memories
  logic [dcl_pkg::PT_BITS-1:0] coord_mem [MAX_POINTS];
  logic [dcl_pkg::PT_BITS-1:0] coord_rdata_q;
  logic [IW-1:0]               coord_raddr;
  logic [LW:0]                 lbl_mem [MAX_POINTS];
  logic [LW:0]                 lbl_rdata_q;
  logic [IW-1:0]               lbl_raddr;
  logic                        lbl_re;
  logic                        lbl_we;
  logic [IW-1:0]               lbl_waddr;
  logic [LW:0]                 lbl_wdata;
  logic [IW-1:0]               seed_mem [MAX_POINTS];
  logic [IW-1:0]               seed_rdata_q;

  logic n_room, hit, push, lbl_noise, lbl_uncl;

  assign n_room    = n_q < N_MAX;
  assign hit       = vc_q && (sum_q <= dcl_pkg::SUM_BITS'(eps_q));
  assign lbl_uncl  = lbl_rdata_q[LW];
  assign lbl_noise = !lbl_rdata_q[LW] && (lbl_rdata_q[LW-1:0] == '0);

  always_comb begin
    push = 1'b0;
    case (mode_q)
      dcl_pkg::SCAN_SEED: push = hit && (qc_q != p_q);
      dcl_pkg::SCAN_EXP:  push = hit && lbl_uncl;
      default:            push = 1'b0;
    endcase
  end

  // coordinate store
  assign coord_raddr = cmd_i.cen_rd ? p_q : q_iss_q[IW-1:0];
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld && n_room) coord_mem[n_q[IW-1:0]] <= pt_data_i;
    coord_rdata_q <= coord_mem[coord_raddr];
  end

  // label store
  assign lbl_re    = cmd_i.lbl_rd_i || vb_q;
  assign lbl_raddr = cmd_i.lbl_rd_i ? i_q[IW-1:0] : qb_q;
  always_comb begin
    lbl_we    = 1'b0;
    lbl_waddr = qc_q;
    lbl_wdata = {1'b0, c_q[LW-1:0]};
    if (cmd_i.ld) begin
      lbl_we    = n_room;
      lbl_waddr = n_q[IW-1:0];
      lbl_wdata = {1'b1, {LW{1'b0}}};
    end else if (cmd_i.noise_wr) begin
      lbl_we    = 1'b1;
      lbl_waddr = p_q;
      lbl_wdata = '0;
    end else if (hit) begin
      case (mode_q)
        dcl_pkg::SCAN_SEED: lbl_we = 1'b1;
        dcl_pkg::SCAN_EXP:  lbl_we = lbl_uncl || lbl_noise;
        default:            lbl_we = 1'b0;
      endcase
    end
  end
  always_ff @(posedge clk_i) begin
    if (lbl_we) lbl_mem[lbl_waddr] <= lbl_wdata;
    if (lbl_re) lbl_rdata_q <= lbl_mem[lbl_raddr];
  end

  // seed queue
  always_ff @(posedge clk_i) begin
    if (push && (tail_q < N_MAX)) seed_mem[tail_q[IW-1:0]] <= qc_q;
    if (cmd_i.q_pop) seed_rdata_q <= seed_mem[head_q[IW-1:0]];
  end

  // distance lanes
  always_comb begin
    for (int k = 0; k < dcl_pkg::DIMS; k++) begin
      logic signed [dcl_pkg::COORD_BITS:0] dif;
      logic [dcl_pkg::DIFF_BITS-1:0]       ad;
      dif = $signed({center_q[k*dcl_pkg::COORD_BITS+dcl_pkg::COORD_BITS-1],
                     center_q[k*dcl_pkg::COORD_BITS +: dcl_pkg::COORD_BITS]})
          - $signed({coord_rdata_q[k*dcl_pkg::COORD_BITS+dcl_pkg::COORD_BITS-1],
                      coord_rdata_q[k*dcl_pkg::COORD_BITS +: dcl_pkg::COORD_BITS]});
      ad = dif[dcl_pkg::COORD_BITS] ? dcl_pkg::DIFF_BITS'(-dif)
                                    : dcl_pkg::DIFF_BITS'(dif);
      sq_d[k] = (dcl_pkg::DIMSEL_BITS'(k) < dims_act) ? ad * ad : '0;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < dcl_pkg::DIMS; k++) sum_d = sum_d + dcl_pkg::SUM_BITS'(sq_q[k]);
  end

  always_ff @(posedge clk_i) begin
    sq_q     <= sq_d;
    sum_q    <= sum_d;
    qa_q     <= q_iss_q[IW-1:0];
    qb_q     <= qa_q;
    qc_q     <= qb_q;
    if (cmd_i.cen_ld) center_q <= coord_rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      issuing_q <= 1'b0;
      q_iss_q <= '0;
      cnt_q <= '0;
      mode_q <= dcl_pkg::SCAN_COUNT;
      n_q <= '0;
      i_q <= '0;
      c_q <= CW'(1);
      p_q <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else begin
      va_q <= issuing_q;
      vb_q <= va_q;
      vc_q <= vb_q;
      if (cmd_i.scan_go) begin
        issuing_q <= 1'b1;
        q_iss_q   <= '0;
        cnt_q     <= '0;
        mode_q    <= cmd_i.scan_mode;
      end else if (issuing_q) begin
        q_iss_q <= q_iss_q + NW'(1);
        if (q_iss_q + NW'(1) == n_q) issuing_q <= 1'b0;
      end
      if (hit && mode_q == dcl_pkg::SCAN_COUNT) cnt_q <= cnt_q + NW'(1);
      if (cmd_i.ld && n_room) n_q <= n_q + NW'(1);
      if (cmd_i.i_clr) i_q <= '0;
      else if (cmd_i.i_inc) i_q <= i_q + NW'(1);
      if (cmd_i.c_inc) c_q <= c_q + CW'(1);
      if (cmd_i.p_from_i) p_q <= i_q[IW-1:0];
      else if (cmd_i.p_from_q) p_q <= seed_rdata_q;
      if (cmd_i.q_clr) begin
        head_q <= '0;
        tail_q <= '0;
      end else begin
        if (cmd_i.q_pop) head_q <= head_q + NW'(1);
        if (push && (tail_q < N_MAX)) tail_q <= tail_q + NW'(1);
      end
      if (cmd_i.set_clr) begin
        n_q <= '0;
        c_q <= CW'(1);
      end
    end
  end

  // output register
  logic [LW+dcl_pkg::LBL_OUT_BITS-1:0] lbl_ext;
  logic [NW+dcl_pkg::IDX_OUT_BITS-1:0] idx_ext;
  assign lbl_ext = {{dcl_pkg::LBL_OUT_BITS{1'b0}}, lbl_rdata_q[LW-1:0]};
  assign idx_ext = {{dcl_pkg::IDX_OUT_BITS{1'b0}}, i_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      point_index_o   <= idx_ext[dcl_pkg::IDX_OUT_BITS-1:0];
      cluster_label_o <= lbl_ext[dcl_pkg::LBL_OUT_BITS-1:0];
      last_label_o    <= (i_q + NW'(1) == n_q);
    end
  end

  assign sts_o.i_at_end    = (i_q == n_q);
  assign sts_o.lbl_unclass = lbl_uncl;
  assign sts_o.core        = {{dcl_pkg::MINP_BITS{1'b0}}, cnt_q} >= KW'(minp_q);
  assign sts_o.scan_done   = !issuing_q && !va_q && !vb_q && !vc_q && !cmd_i.scan_go;
  assign sts_o.q_empty     = (head_q == tail_q);
  assign sts_o.out_free    = !out_valid_o || out_ready_i;

`ifndef ASSERT_OFF
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= tail_q)
    else $error("seed queue head passed tail");
  a_pipe_flow: assert property (@(posedge clk_i) disable iff (!rst_ni) vc_q |-> $past(va_q, 2))
    else $error("distance pipeline out of step");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= N_MAX)
    else $error("point count beyond capacity");
`endif

endmodule

// ===== sv/dcl_ctrl.sv =====
// sequencer for loading, cluster growth and label emission
// depends on dcl_pkg
module dcl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_final_i,
  output logic             in_ready_o,
  input  dcl_pkg::status_t sts_i,
  output dcl_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD, S_OCHK, S_OLBL, S_CADR, S_CLAT, S_SCAN, S_DEC,
    S_QCHK, S_QLAT, S_ERD, S_EOUT, S_EWAIT
  } state_e;

  state_e state_q, state_d;
  dcl_pkg::scan_mode_e mode_q, mode_d;
  logic exp_q, exp_d;

  assign in_ready_o = (state_q == S_LOAD);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    exp_d   = exp_q;
    cmd_o   = '0;
    cmd_o.scan_mode = dcl_pkg::SCAN_COUNT;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.ld = 1'b1;
          if (in_final_i) begin
            cmd_o.i_clr = 1'b1;
            state_d = S_OCHK;
          end
        end
      end
      S_OCHK: begin
        if (sts_i.i_at_end) begin
          cmd_o.i_clr = 1'b1;
          state_d = S_ERD;
        end else begin
          cmd_o.lbl_rd_i = 1'b1;
          state_d = S_OLBL;
        end
      end
      S_OLBL: begin
        if (sts_i.lbl_unclass) begin
          cmd_o.p_from_i = 1'b1;
          exp_d = 1'b0;
          state_d = S_CADR;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d = S_OCHK;
        end
      end
      S_CADR: begin
        cmd_o.cen_rd = 1'b1;
        state_d = S_CLAT;
      end
      S_CLAT: begin
        cmd_o.cen_ld  = 1'b1;
        cmd_o.scan_go = 1'b1;
        cmd_o.scan_mode = dcl_pkg::SCAN_COUNT;
        mode_d  = dcl_pkg::SCAN_COUNT;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = (mode_q == dcl_pkg::SCAN_COUNT) ? S_DEC : S_QCHK;
      end
      S_DEC: begin
        if (sts_i.core) begin
          cmd_o.scan_go   = 1'b1;
          cmd_o.scan_mode = exp_q ? dcl_pkg::SCAN_EXP : dcl_pkg::SCAN_SEED;
          mode_d  = cmd_o.scan_mode;
          state_d = S_SCAN;
        end else if (exp_q) begin
          state_d = S_QCHK;
        end else begin
          cmd_o.noise_wr = 1'b1;
          cmd_o.i_inc    = 1'b1;
          state_d = S_OCHK;
        end
      end
      S_QCHK: begin
        if (sts_i.q_empty) begin
          cmd_o.c_inc = 1'b1;
          cmd_o.i_inc = 1'b1;
          cmd_o.q_clr = 1'b1;
          state_d = S_OCHK;
        end else begin
          cmd_o.q_pop = 1'b1;
          state_d = S_QLAT;
        end
      end
      S_QLAT: begin
        cmd_o.p_from_q = 1'b1;
        exp_d = 1'b1;
        state_d = S_CADR;
      end
      S_ERD: begin
        cmd_o.lbl_rd_i = 1'b1;
        state_d = S_EOUT;
      end
      S_EOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.i_inc  = 1'b1;
          state_d = S_EWAIT;
        end
      end
      S_EWAIT: begin
        if (sts_i.i_at_end) begin
          cmd_o.set_clr = 1'b1;
          cmd_o.q_clr   = 1'b1;
          cmd_o.i_clr   = 1'b1;
          state_d = S_LOAD;
        end else begin
          state_d = S_ERD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      mode_q  <= dcl_pkg::SCAN_COUNT;
      exp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      exp_q   <= exp_d;
    end
  end

`ifndef ASSERT_OFF
  a_one_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.scan_go |-> $past(sts_i.scan_done))
    else $error("scan started while one was running");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.out_ld |-> sts_i.out_free)
    else $error("label overwrites a pending transfer");
  a_load_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.ld |-> state_q == S_LOAD)
    else $error("point stored outside load phase");
`endif

endmodule

// ===== tb/dcl_label_sb.sv =====
// scoreboard class for the density cluster labeler testbench: dbscan label prediction
// and in-order label checking; depends on dcl_pkg
class dcl_label_sb;
  typedef struct packed {
    logic [dcl_pkg::IDX_OUT_BITS-1:0] point_index;
    logic [dcl_pkg::LBL_OUT_BITS-1:0] cluster_label;
    logic                             last_label;
  } label_t;

  localparam int CAP = 64;
  localparam int UNCLASS = -1;

  logic signed [dcl_pkg::COORD_BITS-1:0] pts[CAP][dcl_pkg::DIMS];
  int n_pts;
  int lbl[CAP];
  int min_pts;
  logic [dcl_pkg::EPS_BITS-1:0] eps;
  int dims;
  label_t pending_labels[$];
  int mismatches;

  function void reset_state();
    n_pts = 0;
    min_pts = 4;
    eps = 1;
    dims = 4;
    pending_labels.delete();
    mismatches = 0;
  endfunction

  function void set_reg(logic [dcl_pkg::CFG_IDX_BITS-1:0] idx,
                        logic [dcl_pkg::EPS_BITS-1:0] val);
    case (idx)
      dcl_pkg::CFG_MIN_POINTS: min_pts = val[6:0];
      dcl_pkg::CFG_EPS_SQUARED: eps = val;
      dcl_pkg::CFG_DIMS_IN_USE: dims = val[2:0];
      default: ;
    endcase
  endfunction

  function bit near(int p, int q);
    int nd;
    longint sum;
    longint df;
    nd = dims < 1 ? 1 : (dims > dcl_pkg::DIMS ? dcl_pkg::DIMS : dims);
    sum = 0;
    for (int d = 0; d < nd; d++) begin
      df = longint'(pts[p][d]) - longint'(pts[q][d]);
      sum += df * df;
    end
    return sum <= longint'({30'd0, eps});
  endfunction

  function int n_near(int p);
    int c;
    c = 0;
    for (int q = 0; q < n_pts; q++) if (near(p, q)) c++;
    return c;
  endfunction

  function void expand(int p, int c);
    int seeds[$];
    int s;
    for (int q = 0; q < n_pts; q++)
      if (near(p, q)) begin
        lbl[q] = c;
        if (q != p) seeds.insert(seeds.size(), q);
      end
    while (seeds.size() > 0) begin
      s = seeds.pop_front();
      if (n_near(s) >= min_pts)
        for (int q = 0; q < n_pts; q++)
          if (near(s, q) && (lbl[q] == UNCLASS || lbl[q] == 0)) begin
            if (lbl[q] == UNCLASS) seeds.insert(seeds.size(), q);
            lbl[q] = c;
          end
    end
  endfunction

  // note an accepted point; on the final point run the clustering
  function void note_point(logic signed [dcl_pkg::COORD_BITS-1:0] a, b, c, d, logic fin);
    int next_c;
    label_t e;
    if (n_pts < CAP) begin
      pts[n_pts][0] = a;
      pts[n_pts][1] = b;
      pts[n_pts][2] = c;
      pts[n_pts][3] = d;
      lbl[n_pts] = UNCLASS;
      n_pts++;
    end
    if (!fin) return;
    next_c = 1;
    for (int i = 0; i < n_pts; i++)
      if (lbl[i] == UNCLASS) begin
        if (n_near(i) < min_pts) lbl[i] = 0;
        else begin
          expand(i, next_c);
          next_c++;
        end
      end
    for (int i = 0; i < n_pts; i++) begin
      e.point_index = i[5:0];
      e.cluster_label = lbl[i][6:0];
      e.last_label = (i + 1 == n_pts);
      pending_labels.insert(pending_labels.size(), e);
    end
    n_pts = 0;
  endfunction

  function void check_label(label_t got);
    label_t e;
    if (pending_labels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected label transfer %p", got);
      return;
    end
    e = pending_labels.pop_front();
    if (e !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("label mismatch: expected %p actual %p", e, got);
    end
  endfunction
endclass

// ===== tb/tb.sv =====
// top of the density cluster labeler testbench: drives points and register writes,
// checks labels with dcl_label_sb; depends on dcl_pkg, dcl_if and the core
module tb;

  localparam logic [dcl_pkg::CFG_IDX_BITS-1:0] CFG_NONE = 2'd3;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [dcl_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [dcl_pkg::EPS_BITS-1:0] cfg_wdata_i = '0;
  dcl_pt_if pt_if ();
  dcl_lbl_if lbl_if ();
  dcl_label_sb sb;
  bit no_idle = 0;
  bit hold_off = 0;
  int sent = 0;

  density_cluster_labeler_core dut (
    .clk_i, .rst_ni, .pt_i(pt_if.sink), .lbl_o(lbl_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    pt_if.valid = 0;
    pt_if.coord_a = 0;
    pt_if.coord_b = 0;
    pt_if.coord_c = 0;
    pt_if.coord_d = 0;
    pt_if.final_point = 0;
    lbl_if.ready = 0;
  end

  // label sink with random stalls and a counted long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (lbl_if.valid && lbl_if.ready)
        sb.check_label({lbl_if.point_index, lbl_if.cluster_label, lbl_if.last_label});
      lbl_if.ready <= !hold_off && (no_idle || $urandom_range(99) >= 33);
    end
  end

  // hold off from the final point of the full set, while the next set is offered
  initial begin
    int cnt;
    wait (sent == 83);
    hold_off = 1;
    cnt = 0;
    while (cnt < 20000) begin
      @(posedge clk_i);
      cnt++;
    end
    hold_off = 0;
  end

  task automatic write_reg(logic [dcl_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [dcl_pkg::EPS_BITS-1:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    while (sb.pending_labels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_point(logic signed [15:0] a, b, c, d, logic fin);
    while (!no_idle && $urandom_range(99) < 33) begin
      pt_if.valid <= 0;
      @(posedge clk_i);
    end
    pt_if.valid <= 1;
    pt_if.coord_a <= a;
    pt_if.coord_b <= b;
    pt_if.coord_c <= c;
    pt_if.coord_d <= d;
    pt_if.final_point <= fin;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    sb.note_point(a, b, c, d, fin);
    sent++;
  endtask

  task automatic finish_input();
    pt_if.valid <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] near_val(logic signed [15:0] base, int spread);
    return base + 16'($urandom_range(2 * spread) - spread);
  endfunction

  // one random set: clustered points around a few centres, plus noise
  task automatic random_set(int n, int spread);
    logic signed [15:0] cen[4][4];
    int k;
    for (int i = 0; i < 4; i++)
      for (int d = 0; d < 4; d++) cen[i][d] = 16'($urandom());
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(3);
      if ($urandom_range(9) == 0)
        send_point(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                   i == n - 1);
      else
        send_point(near_val(cen[k][0], spread), near_val(cen[k][1], spread),
                   near_val(cen[k][2], spread), near_val(cen[k][3], spread), i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes with reset settings
    send_point(16'sh7fff, 16'sh8000, 0, -1, 0);
    send_point(16'sh8000, 16'sh7fff, -1, 0, 0);
    send_point(0, 0, 0, 0, 0);
    send_point(0, 0, 0, 1, 0);
    send_point(0, 0, 1, 1, 1);
    finish_input();
    drain();
    write_reg(dcl_pkg::CFG_MIN_POINTS, 0);
    write_reg(dcl_pkg::CFG_EPS_SQUARED, 34'h3ffffffff);
    write_reg(dcl_pkg::CFG_DIMS_IN_USE, 0);
    send_point(16'sh7fff, 5, 5, 5, 0);
    send_point(16'sh8000, 5, 5, 5, 0);
    send_point(1, 2, 3, 4, 1);
    finish_input();
    drain();
    write_reg(dcl_pkg::CFG_MIN_POINTS, 64);
    write_reg(dcl_pkg::CFG_DIMS_IN_USE, 7);
    write_reg(CFG_NONE, 34'h12345);
    send_point(1, 1, 1, 1, 0);
    send_point(2, 2, 2, 2, 1);
    finish_input();
    drain();
    write_reg(dcl_pkg::CFG_MIN_POINTS, 2);
    write_reg(dcl_pkg::CFG_EPS_SQUARED, 2);
    write_reg(dcl_pkg::CFG_DIMS_IN_USE, 2);
    // border point relabel and earlier-cluster overlap
    send_point(0, 0, 0, 0, 0);
    send_point(1, 0, 0, 0, 0);
    send_point(10, 10, 0, 0, 0);
    send_point(11, 11, 0, 0, 0);
    send_point(12, 12, 0, 0, 0);
    send_point(100, 100, 0, 0, 0);
    send_point(0, 1, 9, 9, 1);
    finish_input();
    drain();
    // store full: 66 points, last two ignored; next set offered while labels are held
    write_reg(dcl_pkg::CFG_MIN_POINTS, 3);
    write_reg(dcl_pkg::CFG_EPS_SQUARED, 5000);
    write_reg(dcl_pkg::CFG_DIMS_IN_USE, 3);
    no_idle = 1;
    random_set(66, 40);
    no_idle = 0;
    random_set(12, 40);
    finish_input();
    drain();
    // random sets with varied settings
    while (sent < 180) begin
      write_reg(dcl_pkg::CFG_MIN_POINTS, $urandom_range(5) == 0 ? $urandom_range(64) :
                $urandom_range(1, 5));
      write_reg(dcl_pkg::CFG_EPS_SQUARED, $urandom_range(9) == 0 ?
                dcl_pkg::EPS_BITS'({$urandom(), $urandom()}) :
                dcl_pkg::EPS_BITS'($urandom_range(20000)));
      write_reg(dcl_pkg::CFG_DIMS_IN_USE, $urandom_range(7));
      random_set($urandom_range(9) == 0 ? 64 : $urandom_range(1, 16),
                 $urandom_range(1, 80));
      finish_input();
      drain();
    end
    if (sb.mismatches == 0 && sb.pending_labels.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #80000000;
    $display("tb: FAIL");
    $finish;
  end
endmodule

// ===== density_cluster_labeler_core.f =====
sv/dcl_pkg.sv
sv/dcl_if.sv
sv/dcl_datapath.sv
sv/dcl_ctrl.sv
sv/density_cluster_labeler_core.sv
tb/dcl_label_sb.sv
tb/tb.sv
